// ----- rtl/core/disc_stamp_accumulator_defines.svh -----
// ----------------------------------------------------------------------------
// Disc stamp accumulator assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DISC_STAMP_ACCUMULATOR_DEFINES_SVH
`define DISC_STAMP_ACCUMULATOR_DEFINES_SVH

// same-cycle implication
`define DSA_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dsa assertion failed");

// next-cycle implication
`define DSA_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dsa assertion failed");

`endif

// ----- rtl/core/dsa_pkg.sv -----
// ----------------------------------------------------------------------------
// dsa_pkg
// Types, sizes and codes of the disc stamp accumulator.
// ----------------------------------------------------------------------------
package dsa_pkg;

   localparam int MAX_ROWS    = 256;
   localparam int MAX_COLS    = 256;
   localparam int TOTAL_WIDTH = 32;

   localparam int ROW_BITS   = $clog2(MAX_ROWS);
   localparam int COL_BITS   = $clog2(MAX_COLS);
   localparam int ADDR_BITS  = ROW_BITS + COL_BITS;
   localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;

   // field widths
   localparam int POS_W        = 9;
   localparam int RAD_W        = 9;
   localparam int WEIGHT_W     = 16;
   localparam int GRID_W       = 9;
   localparam int BEST_TOTAL_W = 32;
   localparam int BEST_COUNT_W = 17;

   // request tdata layout
   localparam int REQ_ROW_LSB    = 0;
   localparam int REQ_COL_LSB    = REQ_ROW_LSB + POS_W;
   localparam int REQ_RAD_LSB    = REQ_COL_LSB + POS_W;
   localparam int REQ_WEIGHT_LSB = REQ_RAD_LSB + RAD_W;
   localparam int REQ_USED_W     = REQ_WEIGHT_LSB + WEIGHT_W;
   localparam int REQ_TDATA_W    = ((REQ_USED_W + 7) / 8) * 8;

   // response tdata layout
   localparam int RSP_USED_W  = BEST_TOTAL_W + BEST_COUNT_W;
   localparam int RSP_TDATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_USED_W;

   // signed coordinate width: centre-1 plus or minus radius
   localparam int SPAN_W = POS_W + 2;
   localparam logic signed [SPAN_W-1:0] SPAN_ZERO = '0;
   localparam logic signed [SPAN_W-1:0] SPAN_ONE  = SPAN_W'(1);

   // square root operand width and first trial bit
   localparam int SQ_W = 2 * RAD_W;
   localparam logic [SQ_W-1:0] SQ_BIT_INIT = SQ_W'(1) << (SQ_W - 2);

   localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(256);

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = CSR_IDX_W'(1);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_ROW,
      ST_ROOT,
      ST_SQRT,
      ST_SPAN,
      ST_READ,
      ST_WRITE,
      ST_NEXT,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/core/dsa_ram.sv -----
// ----------------------------------------------------------------------------
// dsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/disc_stamp_accumulator.sv -----
// ----------------------------------------------------------------------------
// disc_stamp_accumulator
// Adds a weight over a clipped filled disc of a cell grid and reports the
// largest cell total and how many cells hold it.
// ----------------------------------------------------------------------------
// One item at a time. After reset the block sweeps the cell RAM to zero, one
// cell per cycle, with req_tready low; csr writes are taken throughout. An
// item then passes a setup step and, for each row offset j from -radius to
// +radius, a row check; a row inside the grid also takes a square root and a
// span step, then a read and a write for each covered cell in that row. The row
// cost is set by the 9-step square root unit and by the cell RAM, whose
// registered read puts a read state and a write state behind each cell. A
// result waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module disc_stamp_accumulator import dsa_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // centre_row[8:0], centre_col[17:9], disc_radius[26:18], weight[42:27]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // best_total[31:0], best_count[48:32]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [GRID_W-1:0]      csr_data
);

   state_type state_ff, state_in;

   logic [GRID_W-1:0] grid_rows_ff, grid_cols_ff;
   logic [ADDR_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [TOTAL_WIDTH-1:0] max_total_ff, max_total_in;
   logic [BEST_COUNT_W-1:0] max_cells_ff, max_cells_in;

   logic signed [SPAN_W-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic signed [SPAN_W-1:0] cr_ff, cr_in, cc_ff, cc_in;
   logic signed [SPAN_W-1:0] j_ff, j_in;
   logic signed [SPAN_W-1:0] col_ff, col_in, col_end_ff, col_end_in;
   logic [RAD_W-1:0] rad_ff, rad_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic [SQ_W-1:0] rad2_ff, rad2_in, mul_ff, mul_in;
   logic [SQ_W-1:0] sq_v_ff, sq_v_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;

   // shared multiplier
   logic signed [SPAN_W-1:0] abs_j;
   logic [RAD_W-1:0] mul_op;
   logic [SQ_W-1:0] mul_op_ext, mul_out;

   // square root step
   logic [SQ_W:0] sq_trial;
   logic sq_take;

   // row and span
   logic signed [SPAN_W-1:0] row_cur, rad_s, h_s, span_lo, span_hi, col_lo, col_hi;
   logic row_ok, span_empty;

   // cell update
   logic [TOTAL_WIDTH-1:0] cell_old, cell_new;
   logic [TOTAL_WIDTH:0] cell_sum;
   logic cell_changed, slot_free;

   logic ram_wr_en, ram_rd_en;
   logic [ADDR_BITS-1:0] ram_addr, cell_addr;
   logic [TOTAL_WIDTH-1:0] ram_wr_data;
   logic [TOTAL_WIDTH-1:0] ram_rd_data;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign abs_j      = j_ff[SPAN_W-1] ? -j_ff : j_ff;
   assign mul_op     = (state_ff == ST_SETUP) ? rad_ff : abs_j[RAD_W-1:0];
   assign mul_op_ext = {{RAD_W{1'b0}}, mul_op};
   assign mul_out    = mul_op_ext * mul_op_ext;

   assign sq_trial = {1'b0, sq_res_ff} + {1'b0, sq_bit_ff};
   assign sq_take  = {1'b0, sq_v_ff} >= sq_trial;

   assign rad_s   = $signed({2'b00, rad_ff});
   assign row_cur = cr_ff + j_ff;
   assign row_ok  = (row_cur >= SPAN_ZERO) && (row_cur < rows_ff);

   assign h_s        = $signed({2'b00, sq_res_ff[RAD_W-1:0]});
   assign span_lo    = cc_ff - h_s;
   assign span_hi    = cc_ff + h_s;
   assign col_lo     = (span_lo < SPAN_ZERO) ? SPAN_ZERO : span_lo;
   assign col_hi     = (span_hi > cols_ff - SPAN_ONE) ? cols_ff - SPAN_ONE : span_hi;
   assign span_empty = col_lo > col_hi;

   assign cell_old     = ram_rd_data;
   assign cell_sum     = {1'b0, cell_old} + {{(TOTAL_WIDTH + 1 - WEIGHT_W){1'b0}}, weight_ff};
   assign cell_new     = cell_sum[TOTAL_WIDTH] ? '1 : cell_sum[TOTAL_WIDTH-1:0];
   assign cell_changed = cell_new != cell_old;

   assign cell_addr = {row_cur[ROW_BITS-1:0], col_ff[COL_BITS-1:0]};

   dsa_ram #(
      .WIDTH (TOTAL_WIDTH),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (cell_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_addr_ff == '1) state_in = ST_IDLE;
         ST_IDLE:  if (req_tvalid) state_in = ST_SETUP;
         ST_SETUP: state_in = ST_ROW;
         ST_ROW:   state_in = row_ok ? ST_ROOT : ST_NEXT;
         ST_ROOT:  state_in = ST_SQRT;
         ST_SQRT:  if (sq_bit_ff[0]) state_in = ST_SPAN;
         ST_SPAN:  state_in = span_empty ? ST_NEXT : ST_READ;
         ST_READ:  state_in = ST_WRITE;
         ST_WRITE: state_in = (col_ff == col_end_ff) ? ST_NEXT : ST_READ;
         ST_NEXT:  state_in = (j_ff == rad_s) ? ST_DONE : ST_ROW;
         ST_DONE:  if (slot_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // datapath controls
   always_comb begin
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      max_total_in = max_total_ff;
      max_cells_in = max_cells_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      cr_in        = cr_ff;
      cc_in        = cc_ff;
      j_in         = j_ff;
      col_in       = col_ff;
      col_end_in   = col_end_ff;
      rad_in       = rad_ff;
      weight_in    = weight_ff;
      rad2_in      = rad2_ff;
      mul_in       = mul_ff;
      sq_v_in      = sq_v_ff;
      sq_res_in    = sq_res_ff;
      sq_bit_in    = sq_bit_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_addr     = cell_addr;
      ram_wr_data  = cell_new;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_addr    = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + ADDR_BITS'(1);
         end
         ST_IDLE: begin
            // grid bounds above the array size act as the array size
            rows_in = ({2'b00, grid_rows_ff} > SPAN_W'(MAX_ROWS)) ? SPAN_W'(MAX_ROWS)
                                                                 : $signed({2'b00, grid_rows_ff});
            cols_in = ({2'b00, grid_cols_ff} > SPAN_W'(MAX_COLS)) ? SPAN_W'(MAX_COLS)
                                                                 : $signed({2'b00, grid_cols_ff});
            cr_in     = $signed({2'b00, req_tdata[REQ_ROW_LSB +: POS_W]}) - SPAN_ONE;
            cc_in     = $signed({2'b00, req_tdata[REQ_COL_LSB +: POS_W]}) - SPAN_ONE;
            rad_in    = req_tdata[REQ_RAD_LSB +: RAD_W];
            weight_in = req_tdata[REQ_WEIGHT_LSB +: WEIGHT_W];
            j_in      = -$signed({2'b00, req_tdata[REQ_RAD_LSB +: RAD_W]});
         end
         ST_SETUP: rad2_in = mul_out;
         ST_ROW:   mul_in = mul_out;
         ST_ROOT: begin
            sq_v_in   = rad2_ff - mul_ff;
            sq_res_in = '0;
            sq_bit_in = SQ_BIT_INIT;
         end
         ST_SQRT: begin
            if (sq_take) begin
               sq_v_in   = sq_v_ff - sq_trial[SQ_W-1:0];
               sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
         end
         ST_SPAN: begin
            col_in     = col_lo;
            col_end_in = col_hi;
         end
         ST_READ: ram_rd_en = 1'b1;
         ST_WRITE: begin
            // an unchanged cell (zero weight or saturated) is not counted
            if (cell_changed) begin
               ram_wr_en = 1'b1;
               if (cell_new > max_total_ff) begin
                  max_total_in = cell_new;
                  max_cells_in = BEST_COUNT_W'(1);
               end else if (cell_new == max_total_ff) begin
                  max_cells_in = max_cells_ff + BEST_COUNT_W'(1);
               end
            end
            col_in = col_ff + SPAN_ONE;
         end
         ST_NEXT: j_in = j_ff + SPAN_ONE;
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, max_cells_ff,
                               max_total_ff[BEST_TOTAL_W-1:0]};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         max_total_ff <= '0;
         max_cells_ff <= '0;
         grid_rows_ff <= GRID_RESET;
         grid_cols_ff <= GRID_RESET;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         max_total_ff <= max_total_in;
         max_cells_ff <= max_cells_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_GRID_ROWS: grid_rows_ff <= csr_data;
               CSR_GRID_COLS: grid_cols_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rows_ff     <= rows_in;
      cols_ff     <= cols_in;
      cr_ff       <= cr_in;
      cc_ff       <= cc_in;
      j_ff        <= j_in;
      col_ff      <= col_in;
      col_end_ff  <= col_end_in;
      rad_ff      <= rad_in;
      weight_ff   <= weight_in;
      rad2_ff     <= rad2_in;
      mul_ff      <= mul_in;
      sq_v_ff     <= sq_v_in;
      sq_res_ff   <= sq_res_in;
      sq_bit_ff   <= sq_bit_in;
   end

endmodule

// ----- rtl/core/dsa_checker.sv -----
// ----------------------------------------------------------------------------
// dsa_checker
// Port-level checks of the disc stamp accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "disc_stamp_accumulator_defines.svh"

module dsa_checker import dsa_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [BEST_TOTAL_W-1:0] best_total;
   logic [BEST_COUNT_W-1:0] best_count;

   assign best_total = rsp_tdata[BEST_TOTAL_W-1:0];
   assign best_count = rsp_tdata[BEST_TOTAL_W +: BEST_COUNT_W];

   // a stalled result holds
   `DSA_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // an accepted item leaves the block busy in the next cycle
   `DSA_ASSERT_NXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)

   // a nonzero maximum always has at least one cell, and no cells means zero
   `DSA_ASSERT_IMP(a_total_count_pair, rsp_tvalid, (best_total == '0) == (best_count == '0))

   // never more cells at the maximum than the grid holds
   `DSA_ASSERT_IMP(a_count_bound, rsp_tvalid, best_count <= BEST_COUNT_W'(CELL_COUNT))

endmodule

bind disc_stamp_accumulator dsa_checker u_dsa_checker (.*);

// ----- tb/sv/tb_disc_stamp_accumulator.sv -----
// ----------------------------------------------------------------------------
// tb_disc_stamp_accumulator
// Streams disc items into the accumulator under random back-pressure and
// compares every best total / best count item against a behavioral grid model
// kept in the testbench. Grid size registers are changed between phases.
// ----------------------------------------------------------------------------
module tb_disc_stamp_accumulator import dsa_pkg::*;;

   // the limit is set well above what a run needs, even if every random disc
   // were drawn at its largest radius on the full grid
   localparam int CYCLE_LIMIT = 20_000_000;
   localparam int SHOWN_FAILS = 10;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = CSR_IDX_W'(3);

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic [RAD_W-1:0]    radius;
      logic [POS_W-1:0]    col;
      logic [POS_W-1:0]    row;
   } disc_item_type;

   typedef struct packed {
      logic [BEST_COUNT_W-1:0] count;
      logic [BEST_TOTAL_W-1:0] total;
   } best_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [GRID_W-1:0]      csr_data = '0;

   // grid model
   logic [TOTAL_WIDTH-1:0] grid_sum [CELL_COUNT];
   logic [TOTAL_WIDTH-1:0] top_total = '0;
   logic [31:0]            top_cells = '0;
   logic [GRID_W-1:0]      cfg_rows = GRID_RESET;
   logic [GRID_W-1:0]      cfg_cols = GRID_RESET;

   disc_item_type disc_q[$];
   best_type      best_q[$];
   disc_item_type on_bus;
   int            send_idle = 0;
   int            recv_idle = 0;
   int            fail_count = 0;
   int            cycle_count = 0;

   disc_stamp_accumulator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      // centre_row[8:0], centre_col[17:9], disc_radius[26:18], weight[42:27]
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // best_total[31:0], best_count[48:32]
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int clip_grid(input logic [GRID_W-1:0] v, input int lim);
      return (int'(v) > lim) ? lim : int'(v);
   endfunction

   // floor square root by bisection
   function automatic int floor_root(input int v);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = 1 << RAD_W;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (mid * mid <= v) lo = mid;
         else hi = mid;
      end
      return lo;
   endfunction

   // adds one disc to the grid model, returns the best total / count after it
   function automatic best_type stamp_disc(input disc_item_type it);
      int                     rows_eff;
      int                     cols_eff;
      int                     cr;
      int                     cc;
      int                     rad;
      int                     row;
      int                     half;
      int                     c_lo;
      int                     c_hi;
      int                     j;
      int                     c;
      int unsigned            addr;
      logic [TOTAL_WIDTH:0]   sum;
      logic [TOTAL_WIDTH-1:0] was;
      logic [TOTAL_WIDTH-1:0] nxt;
      best_type               res;
      rows_eff = clip_grid(cfg_rows, MAX_ROWS);
      cols_eff = clip_grid(cfg_cols, MAX_COLS);
      cr  = int'(it.row) - 1;
      cc  = int'(it.col) - 1;
      rad = int'(it.radius);
      for (j = -rad; j <= rad; j++) begin
         row = cr + j;
         if (row < 0 || row >= rows_eff) continue;
         half = floor_root(rad * rad - j * j);
         c_lo = (cc - half < 0) ? 0 : cc - half;
         c_hi = (cc + half > cols_eff - 1) ? cols_eff - 1 : cc + half;
         for (c = c_lo; c <= c_hi; c++) begin
            addr = row * MAX_COLS + c;
            was  = grid_sum[addr];
            sum  = {1'b0, was} + (TOTAL_WIDTH+1)'(it.weight);
            nxt  = sum[TOTAL_WIDTH] ? '1 : sum[TOTAL_WIDTH-1:0];
            // unchanged cells (zero weight, saturated) are not counted
            if (nxt == was) continue;
            grid_sum[addr] = nxt;
            if (nxt > top_total) begin
               top_total = nxt;
               top_cells = 1;
            end else if (nxt == top_total) begin
               top_cells++;
            end
         end
      end
      res.total = top_total[BEST_TOTAL_W-1:0];
      res.count = top_cells[BEST_COUNT_W-1:0];
      return res;
   endfunction

   function automatic disc_item_type make_disc(input int r, input int c, input int rad,
                                               input int w);
      disc_item_type it;
      it.row    = POS_W'(r);
      it.col    = POS_W'(c);
      it.radius = RAD_W'(rad);
      it.weight = WEIGHT_W'(w);
      return it;
   endfunction

   // random disc; big radii only where the grid in use is small
   function automatic disc_item_type rand_disc();
      int rows_eff;
      int cols_eff;
      int p;
      int rad;
      int w;
      int r;
      int c;
      rows_eff = clip_grid(cfg_rows, MAX_ROWS);
      cols_eff = clip_grid(cfg_cols, MAX_COLS);
      p = $urandom_range(0, 99);
      if (p < 75) rad = $urandom_range(0, 8);
      else if (p < 90) rad = $urandom_range(9, 40);
      else if (rows_eff * cols_eff <= 2048) rad = $urandom_range(0, 511);
      else rad = $urandom_range(0, 60);
      if ($urandom_range(0, 9) < 7) begin
         r = $urandom_range(1, (rows_eff < 1) ? 1 : rows_eff);
         c = $urandom_range(1, (cols_eff < 1) ? 1 : cols_eff);
      end else begin
         r = $urandom_range(0, 511);
         c = $urandom_range(0, 511);
      end
      p = $urandom_range(0, 9);
      if (p == 0) w = 0;
      else if (p == 1) w = 65535;
      else if (p < 6) w = $urandom_range(1, 4);   // small weights make ties
      else w = $urandom_range(0, 65535);
      return make_disc(r, c, rad, w);
   endfunction

   task automatic add_disc(input disc_item_type it);
      disc_q.insert(disc_q.size(), it);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            best_q.insert(best_q.size(), stamp_disc(on_bus));
         end
         if (!req_tvalid || req_tready) begin
            if (disc_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
               on_bus = disc_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_TDATA_W'(on_bus);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      best_type got;
      best_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = best_type'(rsp_tdata[RSP_USED_W-1:0]);
            if (best_q.size() == 0) begin
               if (fail_count < SHOWN_FAILS)
                  $display("unexpected item: total %0d count %0d", got.total, got.count);
               fail_count++;
            end else begin
               want = best_q.pop_front();
               if (got.total != want.total || got.count != want.count) begin
                  if (fail_count < SHOWN_FAILS)
                     $display("mismatch: expected total %0d count %0d, got total %0d count %0d",
                              want.total, want.count, got.total, got.count);
                  fail_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= GRID_W'(val);
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_GRID_ROWS) cfg_rows = GRID_W'(val);
      else if (idx == CSR_GRID_COLS) cfg_cols = GRID_W'(val);
      csr_valid <= 1'b0;
   endtask

   // checked between edges, once the driver and monitor have settled
   task automatic wait_drained();
      do @(negedge clock); while (disc_q.size() != 0 || req_tvalid || best_q.size() != 0);
   endtask

   task automatic set_grid(input int rows, input int cols);
      wait_drained();
      write_reg(CSR_GRID_ROWS, rows);
      write_reg(CSR_GRID_COLS, cols);
   endtask

   task automatic run_random(input int n);
      repeat (n) add_disc(rand_disc());
   endtask

   initial begin
      foreach (grid_sum[i]) grid_sum[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle = 33;
      recv_idle = 75;

      // default 256 x 256 grid
      add_disc(make_disc(1, 1, 0, 0));          // zero weight on a fresh grid
      add_disc(make_disc(128, 128, 511, 1));    // whole grid, every cell at max
      add_disc(make_disc(1, 1, 0, 65535));
      add_disc(make_disc(256, 256, 0, 65535));  // tie at the far corner
      add_disc(make_disc(0, 0, 2, 100));        // centre off the grid
      add_disc(make_disc(300, 300, 100, 7));    // clipped partial disc
      add_disc(make_disc(511, 511, 300, 7));    // nothing falls inside
      add_disc(make_disc(256, 1, 5, 65535));
      add_disc(make_disc(128, 128, 3, 0));      // zero weight over cells
      add_disc(make_disc(128, 128, 3, 65535));

      set_grid(1, 1);
      add_disc(make_disc(1, 1, 511, 3));
      add_disc(make_disc(2, 2, 1, 3));
      add_disc(make_disc(0, 0, 511, 9));

      set_grid(0, 256);                         // no rows: no cells
      add_disc(make_disc(1, 1, 4, 50));
      set_grid(511, 0);                         // no cols: no cells
      add_disc(make_disc(5, 5, 4, 50));

      set_grid(511, 511);                       // both clip to the maximum
      wait_drained();
      write_reg(CSR_SPARE_2, 5);
      write_reg(CSR_SPARE_3, 511);
      add_disc(make_disc(256, 256, 10, 65535));
      add_disc(make_disc(1, 256, 6, 1));

      set_grid(12, 20);
      run_random(40);

      wait_drained();
      send_idle = 75;
      recv_idle = 33;
      set_grid($urandom_range(1, 511), $urandom_range(1, 511));
      run_random(43);

      wait_drained();
      send_idle = 0;
      recv_idle = 0;
      set_grid(256, 256);
      run_random(40);

      wait_drained();
      repeat (1000) @(posedge clock);
      fail_count += best_q.size();
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
